// File: rtl/brm_pkg.sv
// Shared types and constants for the beat rate meter.
`timescale 1ns / 1ps

package brm_pkg;

    // Field widths
    localparam int TIME_W = 32;
    localparam int BPM_W  = 20;

    // Milliseconds in one minute
    localparam int MS_PER_MINUTE = 60000;

    // Divider step count: one quotient bit per step
    localparam int DIV_STEPS = BPM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } t_state;

endpackage

// File: rtl/brm_channels.sv
// Valid/ready channel interfaces for beat input and rate output.
`timescale 1ns / 1ps

interface brm_beat_if;
    logic                        valid;
    logic                        ready;
    logic [brm_pkg::TIME_W-1:0]  beat_time_ms;

    modport source (output valid, output beat_time_ms, input ready);
    modport sink   (input valid, input beat_time_ms, output ready);
endinterface

interface brm_rate_if;
    logic                        valid;
    logic                        ready;
    logic [brm_pkg::BPM_W-1:0]   beats_per_minute;

    modport source (output valid, output beats_per_minute, input ready);
    modport sink   (input valid, input beats_per_minute, output ready);
endinterface

// File: rtl/brm_div.sv
// Restoring divider: one quotient bit per cycle, zero divisor saturates.
`timescale 1ns / 1ps

module brm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [brm_pkg::BPM_W-1:0]   i_dividend,
    input  logic [brm_pkg::TIME_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [brm_pkg::BPM_W-1:0]   o_quotient
);

    logic                                r_busy;
    logic                                r_done;
    logic [brm_pkg::DIV_CNT_W-1:0]       r_cnt;
    logic [brm_pkg::TIME_W-1:0]          r_rem;
    logic [brm_pkg::TIME_W-1:0]          r_div;
    logic [brm_pkg::BPM_W-1:0]           r_quo;

    logic [brm_pkg::TIME_W:0]            trial;
    logic [brm_pkg::TIME_W:0]            diff;
    logic                                q_bit;
    logic [brm_pkg::TIME_W-1:0]          n_rem;

    // Shared compare/subtract: bring down the next dividend bit
    always_comb begin
        trial = {r_rem, r_quo[brm_pkg::BPM_W-1]};
        diff  = trial - {1'b0, r_div};
        q_bit = (trial >= {1'b0, r_div});
        n_rem = q_bit ? diff[brm_pkg::TIME_W-1:0] : trial[brm_pkg::TIME_W-1:0];
    end

    // Control: start, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (i_divisor == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == brm_pkg::DIV_CNT_W'(brm_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[brm_pkg::BPM_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/beat_rate_meter.sv
// Beat rate meter top level: timestamp ring, sequencer and output register.
//
// Each accepted beat timestamp is written into a ring of the last BEATS beats.
// When the slot it replaces held an earlier beat (nonzero timestamp), one
// result is produced: 60000*BEATS divided by the wrapped 32-bit time between
// the two beats, truncated; a zero interval gives 60000*BEATS. Beats whose
// slot is empty produce no result and leave the block ready the next cycle.
// A beat that produces a result holds off the next input transfer while the
// shared restoring divider is started and retires one quotient bit per
// cycle, and until the result is loaded into the output register. A zero
// interval skips the divide steps.
// The block takes one beat at a time; a finished rate waits in the output
// register. New beats are held off while a divide runs and while a second
// finished rate waits for that register to drain. The ring is empty after reset.
`timescale 1ns / 1ps

module beat_rate_meter #(
    parameter int BEATS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    brm_beat_if.sink        i_beat,
    brm_rate_if.source      o_rate
);

    localparam int PTR_W = (BEATS > 1) ? $clog2(BEATS) : 1;
    localparam logic [brm_pkg::BPM_W-1:0] RATE_NUM =
        brm_pkg::BPM_W'(brm_pkg::MS_PER_MINUTE * BEATS);

    brm_pkg::t_state                     r_state;
    brm_pkg::t_state                     n_state;

    logic [brm_pkg::TIME_W-1:0]          r_ring [BEATS];
    logic [BEATS-1:0]                    r_ring_vld;
    logic [PTR_W-1:0]                    r_ptr;
    logic [PTR_W-1:0]                    n_ptr;

    logic                                r_out_vld;
    logic [brm_pkg::BPM_W-1:0]           r_out_bpm;

    logic [brm_pkg::TIME_W-1:0]          old_time;
    logic [brm_pkg::TIME_W-1:0]          elapsed;
    logic                                has_old;
    logic                                accept;
    logic                                out_free;
    logic                                in_ready;
    logic                                div_start;
    logic                                out_load;
    logic                                div_done;
    logic [brm_pkg::BPM_W-1:0]           div_quo;

    // Read the slot under the pointer; an unwritten slot reads as empty
    always_comb begin
        old_time = r_ring_vld[r_ptr] ? r_ring[r_ptr] : '0;
        has_old  = (old_time != '0);
        elapsed  = i_beat.beat_time_ms - old_time;
        n_ptr    = (r_ptr == PTR_W'(BEATS - 1)) ? '0 : r_ptr + 1'b1;
    end

    assign accept   = i_beat.valid && in_ready;
    assign out_free = !r_out_vld || o_rate.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            brm_pkg::ST_IDLE: begin
                if (accept && has_old) n_state = brm_pkg::ST_DIV;
            end
            brm_pkg::ST_DIV: begin
                if (div_done) n_state = out_free ? brm_pkg::ST_IDLE : brm_pkg::ST_HOLD;
            end
            brm_pkg::ST_HOLD: begin
                if (out_free) n_state = brm_pkg::ST_IDLE;
            end
            default: n_state = brm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            brm_pkg::ST_IDLE: begin
                in_ready  = 1'b1;
                div_start = i_beat.valid && has_old;
            end
            brm_pkg::ST_DIV: begin
                out_load = div_done && out_free;
            end
            brm_pkg::ST_HOLD: begin
                out_load = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Store the new beat and advance the pointer on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_ptr      <= '0;
        end else if (accept) begin
            r_ring_vld[r_ptr] <= 1'b1;
            r_ptr             <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_ptr] <= i_beat.beat_time_ms;
        end
    end

    // Shared divider
    brm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (RATE_NUM),
        .i_divisor  (elapsed),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Output register: load a finished rate, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_rate.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_bpm <= div_quo;
        end
    end

    assign i_beat.ready            = in_ready;
    assign o_rate.valid            = r_out_vld;
    assign o_rate.beats_per_minute = r_out_bpm;

endmodule

// File: bench/tb.sv
// Self-checking testbench for the beat rate meter: directed and random beat trains.
`timescale 1ns / 1ps

module tb;

    localparam int RING_DEPTH = 4;
    localparam logic [brm_pkg::TIME_W-1:0] RATE_NUM = brm_pkg::MS_PER_MINUTE * RING_DEPTH;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_BEATS = 900;

    logic i_clk;
    logic i_rst_n;

    brm_beat_if beat_ch ();
    brm_rate_if rate_ch ();

    beat_rate_meter #(
        .BEATS (RING_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat_ch),
        .o_rate  (rate_ch)
    );

    // Mirror of the block state and the rates still owed by it
    logic [brm_pkg::TIME_W-1:0] beat_ring [RING_DEPTH];
    int                         ring_wr;
    logic [brm_pkg::BPM_W-1:0]  pending_bpm [$];

    int  mismatch_count;
    int  quiet_cycles;
    int  sink_hold;
    bit  src_idle;
    bit  sink_idle;

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the mirrored ring by one beat and queue the rate it yields
    function automatic void predict_rate(input logic [brm_pkg::TIME_W-1:0] now);
        logic [brm_pkg::TIME_W-1:0] prior;
        logic [brm_pkg::TIME_W-1:0] elapsed;
        logic [brm_pkg::TIME_W-1:0] rate;
        prior = beat_ring[ring_wr];
        if (prior != '0) begin
            elapsed = now - prior;
            rate = (elapsed == '0) ? RATE_NUM : RATE_NUM / elapsed;
            pending_bpm.push_back(rate[brm_pkg::BPM_W-1:0]);
        end
        beat_ring[ring_wr] = now;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
    endfunction

    // Present one beat, hold it until the transfer, then predict
    task automatic send_beat(input logic [brm_pkg::TIME_W-1:0] stamp);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            beat_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        beat_ch.valid        <= 1'b1;
        beat_ch.beat_time_ms <= stamp;
        @(posedge i_clk);
        while (!beat_ch.ready) @(posedge i_clk);
        predict_rate(stamp);
    endtask

    // Send a beat a given distance after the one it replaces in the ring
    task automatic send_after(input logic [brm_pkg::TIME_W-1:0] delta);
        send_beat(beat_ring[ring_wr] + delta);
    endtask

    // Rate sink: random stalls when enabled
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            rate_ch.ready <= 1'b0;
        end else begin
            rate_ch.ready <= 1'b1;
            if (sink_idle && $urandom_range(0, 3) == 0)
                sink_hold <= pick_gap();
        end
    end

    // Compare each rate transfer with the oldest prediction
    always @(posedge i_clk) begin
        logic [brm_pkg::BPM_W-1:0] want;
        if (i_rst_n && rate_ch.valid && rate_ch.ready) begin
            if (pending_bpm.size() == 0) begin
                $display("%0t: unexpected rate transfer: expected none, actual %0d",
                         $time, rate_ch.beats_per_minute);
                mismatch_count++;
            end else begin
                want = pending_bpm.pop_front();
                if (rate_ch.beats_per_minute !== want) begin
                    $display("%0t: beats_per_minute mismatch: expected %0d, actual %0d",
                             $time, want, rate_ch.beats_per_minute);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((beat_ch.valid && beat_ch.ready) || (rate_ch.valid && rate_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Fill the empty ring: no rate until a slot holds an earlier beat
    task automatic test_empty_ring();
        send_beat(32'hFFFF_FF00);
        send_beat(32'hFFFF_FF80);
        send_beat(32'hFFFF_FFC0);
        send_beat(32'hFFFF_FFFF);
    endtask

    // Cross the 2^32 boundary with a steady beat
    task automatic test_wrapped_time();
        repeat (RING_DEPTH) send_after(32'd1000);
    endtask

    // Zero interval saturates; tiny and huge intervals hit both ends of the range
    task automatic test_rate_extremes();
        send_after(32'd0);
        send_after(32'd1);
        send_after(32'd2);
        send_after(RATE_NUM);
        send_after(RATE_NUM + 32'd1);
    endtask

    // Timestamp earlier than the slot gives a huge interval and a zero rate
    task automatic test_backward_time();
        send_after(32'hFFFF_FFFF);
        send_after(32'h8000_0000);
    endtask

    // A beat at time zero reads back as an empty slot one lap later
    task automatic test_zero_stamp();
        send_beat('0);
        repeat (RING_DEPTH - 1) send_after(32'd500);
        send_beat(32'd777);
        send_after(32'd600);
    endtask

    // Mostly regular beat trains with random content, plus noise and broken trains
    task automatic test_random_beats(input int n_items);
        int                         sent;
        int                         burst;
        int                         kind;
        logic [brm_pkg::TIME_W-1:0] stamp;
        logic [brm_pkg::TIME_W-1:0] period;
        sent = 0;
        while (sent < n_items) begin
            src_idle  = ($urandom_range(0, 4) != 0);
            sink_idle = ($urandom_range(0, 4) != 0);
            kind  = $urandom_range(0, 19);
            burst = $urandom_range(4, 30);
            if (kind < 15) begin
                case ($urandom_range(0, 3))
                    0:       period = $urandom_range(1, 16);
                    1:       period = $urandom_range(250, 2000);
                    2:       period = $urandom_range(2000, 70000);
                    default: period = $urandom_range(60000, 32'h0100_0000);
                endcase
                // Start some trains just short of the wrap point
                if ($urandom_range(0, 3) == 0)
                    stamp = '0 - $urandom_range(0, 8) * period;
                else
                    stamp = $urandom;
                for (int k = 0; k < burst; k++) begin
                    stamp = stamp + period + $urandom_range(0, period / 8);
                    send_beat(stamp);
                    sent++;
                end
            end else if (kind < 18) begin
                for (int k = 0; k < burst; k++) begin
                    stamp = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
                    send_beat(stamp);
                    sent++;
                end
            end else begin
                // Repeated, backward and zero stamps mixed into a train
                stamp = $urandom;
                for (int k = 0; k < burst; k++) begin
                    case ($urandom_range(0, 3))
                        0:       stamp = stamp;
                        1:       stamp = stamp - $urandom_range(1, 5000);
                        2:       stamp = '0;
                        default: stamp = stamp + $urandom_range(1, 3000);
                    endcase
                    send_beat(stamp);
                    sent++;
                end
            end
        end
    endtask

    // Reset, run the tests in turn, drain and report
    initial begin
        i_rst_n              = 1'b0;
        beat_ch.valid        = 1'b0;
        beat_ch.beat_time_ms = '0;
        rate_ch.ready        = 1'b0;
        mismatch_count       = 0;
        quiet_cycles         = 0;
        sink_hold            = 0;
        src_idle             = 1'b1;
        sink_idle            = 1'b1;
        ring_wr              = 0;
        for (int k = 0; k < RING_DEPTH; k++) beat_ring[k] = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_ring();
        test_wrapped_time();
        test_rate_extremes();
        test_backward_time();
        test_zero_stamp();
        test_random_beats(RANDOM_BEATS);

        @(negedge i_clk);
        beat_ch.valid <= 1'b0;
        while (pending_bpm.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
rtl/brm_pkg.sv
rtl/brm_channels.sv
rtl/brm_div.sv
rtl/beat_rate_meter.sv
bench/tb.sv
